FILE: sv/pending_request_queue_with_cancel_top_assert.svh
`ifndef PENDING_REQUEST_QUEUE_WITH_CANCEL_TOP_ASSERT_SVH
`define PENDING_REQUEST_QUEUE_WITH_CANCEL_TOP_ASSERT_SVH

// same-cycle implication
`define PRQC_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pending request queue port check failed");

// next-cycle implication
`define PRQC_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pending request queue port check failed");

`endif

FILE: sv/prqc_pkg.sv
package prqc_pkg;

	localparam int POOL_DEPTH     = 256;
	localparam int NUM_REQUESTERS = 256;
	localparam int NUM_SOURCES    = 50;
	localparam int DEFAULT_BATCH  = 6;
	localparam int MAX_BATCH      = 64;

	localparam int IDX_W     = $clog2(POOL_DEPTH);
	localparam int PTR_W     = IDX_W + 1;
	localparam int CNT_W     = $clog2(POOL_DEPTH + 1);
	localparam int RQ_IDX_W  = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
	localparam int SRC_IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int LIM_W     = 7;

	localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_DEPTH);

	localparam logic [1:0] ACT_ENQ    = 2'd0;
	localparam logic [1:0] ACT_CANCEL = 2'd1;
	localparam logic [1:0] ACT_TICK   = 2'd2;
	localparam logic [1:0] ACT_IGNORE = 2'd3;

	localparam logic [2:0] KIND_QUEUED     = 3'd0;
	localparam logic [2:0] KIND_REFUSED    = 3'd1;
	localparam logic [2:0] KIND_CANCELLED  = 3'd2;
	localparam logic [2:0] KIND_NONE       = 3'd3;
	localparam logic [2:0] KIND_DISPATCHED = 3'd4;
	localparam logic [2:0] KIND_TICK_IDLE  = 3'd5;

	typedef enum logic [2:0] {
		OP_ENQ    = 3'd0,
		OP_BAD    = 3'd1,
		OP_CANCEL = 3'd2,
		OP_NONE   = 3'd3,
		OP_TICK   = 3'd4
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [7:0]        req;
		logic [15:0]       sel;
		logic [31:0]       par;
		logic [5:0]        src;
		logic              src_ok;
		logic [LIM_W-1:0]  limit;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  req;
		logic [15:0] sel;
		logic [31:0] par;
		logic [5:0]  src;
	} ent_t;

endpackage

FILE: sv/prqc_front.sv
module prqc_front (
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                action,
	input  logic [7:0]                requester,
	input  logic [15:0]               selection_index,
	input  logic [31:0]               move_params,
	input  logic [5:0]                source_id,
	input  logic [prqc_pkg::LIM_W-1:0] batch_limit,
	input  logic                      q_full,
	output logic                      push,
	output prqc_pkg::cmd_t            cmd
);
	import prqc_pkg::*;

	logic req_ok;
	logic src_ok;

	assign in_ready = !q_full;
	assign req_ok   = {1'b0, requester} < 9'(NUM_REQUESTERS);
	assign src_ok   = source_id < 6'(NUM_SOURCES);
	// unknown action is taken and dropped
	assign push     = in_valid && !q_full && (action != ACT_IGNORE);

	always_comb begin
		cmd.req    = requester;
		cmd.sel    = selection_index;
		cmd.par    = move_params;
		cmd.src    = source_id;
		cmd.src_ok = src_ok;
		cmd.limit  = (batch_limit > LIM_W'(MAX_BATCH)) ? LIM_W'(MAX_BATCH) : batch_limit;
		unique case (action)
			ACT_ENQ:    cmd.op = (req_ok && src_ok) ? OP_ENQ : OP_BAD;
			ACT_CANCEL: cmd.op = req_ok ? OP_CANCEL : OP_NONE;
			ACT_TICK:   cmd.op = OP_TICK;
			default:    cmd.op = OP_TICK;
		endcase
	end
endmodule

FILE: sv/prqc_cmdq.sv
module prqc_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  prqc_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           cmd_valid,
	output prqc_pkg::cmd_t cmd,
	input  logic           pop
);
	import prqc_pkg::*;

	cmd_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= push_cmd;
	end
endmodule

FILE: sv/prqc_back.sv
module prqc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  prqc_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     result_kind,
	output logic [7:0]     out_requester,
	output logic [15:0]    out_selection,
	output logic [31:0]    out_params,
	output logic [5:0]     out_source,
	output logic [8:0]     occupancy,
	output logic [8:0]     high_water,
	output logic [8:0]     source_occupancy,
	output logic           last_result
);
	import prqc_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_OWN   = 9'b000000010,
		ST_U2    = 9'b000000100,
		ST_U3    = 9'b000001000,
		ST_A1    = 9'b000010000,
		ST_A2    = 9'b000100000,
		ST_A3    = 9'b001000000,
		ST_EMIT3 = 9'b010000000,
		ST_EMIT5 = 9'b100000000
	} state_t;

	// pool memories
	ent_t             ent_mem  [POOL_DEPTH];
	logic [PTR_W-1:0] nxt_mem  [POOL_DEPTH];
	logic [PTR_W-1:0] prv_mem  [POOL_DEPTH];
	logic [IDX_W-1:0] fs_mem   [POOL_DEPTH];
	logic [IDX_W-1:0] own_mem  [NUM_REQUESTERS];
	logic [CNT_W-1:0] tally_mem[NUM_SOURCES];

	logic own_vld_q  [NUM_REQUESTERS];
	logic tally_vld_q[NUM_SOURCES];

	ent_t             ent_rd;
	logic [PTR_W-1:0] nxt_rd, prv_rd;
	logic [IDX_W-1:0] fs_rd, own_rd;
	logic [CNT_W-1:0] tally_rd;

	state_t           state_q, state_d;
	cmd_t             cmd_q, cmd_d;
	logic [IDX_W-1:0] slot_q, slot_d;
	logic [PTR_W-1:0] ptr_q, ptr_d;
	logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
	logic [CNT_W-1:0] pend_q, pend_d, peak_q, peak_d;
	logic [CNT_W-1:0] fs_cnt_q, fs_cnt_d, fr_cnt_q, fr_cnt_d;
	logic [CNT_W-1:0] tnew_q, tnew_d;
	logic [LIM_W-1:0] k_q, k_d;

	logic                 link_re, own_re, tally_re, fs_re;
	logic [IDX_W-1:0]     link_ra, own_ra, fs_ra;
	logic [SRC_IDX_W-1:0] tally_ra;
	logic                 ent_we, nxt_we, prv_we, fs_we, own_we, tally_we, own_clr;
	logic [IDX_W-1:0]     ent_wa, nxt_wa, prv_wa, fs_wa;
	logic [RQ_IDX_W-1:0]  own_wa, clr_wa;
	logic [SRC_IDX_W-1:0] tally_wa;
	ent_t                 ent_wd;
	logic [PTR_W-1:0]     nxt_wd, prv_wd;
	logic [IDX_W-1:0]     fs_wd, own_wd;
	logic [CNT_W-1:0]     tally_wd;

	logic             emit, emit_ok, e_last;
	logic [2:0]       e_kind;
	ent_t             e_ent;
	logic [CNT_W-1:0] e_socc;
	logic [CNT_W-1:0] tv_link, tv_cmd, fs_top;
	logic [IDX_W-1:0] alloc;

	assign emit_ok = !out_valid || out_ready;
	assign fs_top  = fs_cnt_q - CNT_W'(1);
	assign alloc   = (fr_cnt_q < CNT_W'(POOL_DEPTH)) ? fr_cnt_q[IDX_W-1:0] : fs_rd;
	assign tv_link = tally_vld_q[ent_rd.src[SRC_IDX_W-1:0]] ? tally_rd : '0;
	assign tv_cmd  = (cmd_q.src_ok && tally_vld_q[cmd_q.src[SRC_IDX_W-1:0]]) ? tally_rd : '0;

	always_comb begin
		state_d  = state_q;
		cmd_d    = cmd_q;
		slot_d   = slot_q;
		ptr_d    = ptr_q;
		head_d   = head_q;
		tail_d   = tail_q;
		pend_d   = pend_q;
		peak_d   = peak_q;
		fs_cnt_d = fs_cnt_q;
		fr_cnt_d = fr_cnt_q;
		tnew_d   = tnew_q;
		k_d      = k_q;
		cmd_pop  = 1'b0;
		link_re  = 1'b0; link_ra = '0;
		own_re   = 1'b0; own_ra = '0;
		tally_re = 1'b0; tally_ra = '0;
		fs_re    = 1'b0; fs_ra = '0;
		ent_we   = 1'b0; ent_wa = '0; ent_wd = '0;
		nxt_we   = 1'b0; nxt_wa = '0; nxt_wd = '0;
		prv_we   = 1'b0; prv_wa = '0; prv_wd = '0;
		fs_we    = 1'b0; fs_wa = '0; fs_wd = '0;
		own_we   = 1'b0; own_wa = '0; own_wd = '0;
		own_clr  = 1'b0; clr_wa = '0;
		tally_we = 1'b0; tally_wa = '0; tally_wd = '0;
		emit     = 1'b0;
		e_kind   = KIND_QUEUED;
		e_ent    = '0;
		e_socc   = '0;
		e_last   = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					cmd_d   = cmd;
					k_d     = '0;
					case (cmd.op)
						OP_ENQ, OP_CANCEL: begin
							own_re  = 1'b1;
							own_ra  = cmd.req[RQ_IDX_W-1:0];
							state_d = ST_OWN;
						end
						OP_BAD:  state_d = ST_A1;
						OP_NONE: state_d = ST_EMIT3;
						default: begin
							if (cmd.limit == '0 || head_q == NIL) begin
								state_d = ST_EMIT5;
							end else begin
								slot_d  = head_q[IDX_W-1:0];
								link_re = 1'b1;
								link_ra = head_q[IDX_W-1:0];
								state_d = ST_U2;
							end
						end
					endcase
				end
			end
			ST_OWN: begin
				if (own_vld_q[cmd_q.req[RQ_IDX_W-1:0]]) begin
					slot_d  = own_rd;
					link_re = 1'b1;
					link_ra = own_rd;
					state_d = ST_U2;
				end else if (cmd_q.op == OP_ENQ) begin
					state_d = ST_A1;
				end else begin
					state_d = ST_EMIT3;
				end
			end
			ST_U2: begin
				if (prv_rd != NIL) begin
					nxt_we = 1'b1;
					nxt_wa = prv_rd[IDX_W-1:0];
					nxt_wd = nxt_rd;
				end else begin
					head_d = nxt_rd;
				end
				if (nxt_rd != NIL) begin
					prv_we = 1'b1;
					prv_wa = nxt_rd[IDX_W-1:0];
					prv_wd = prv_rd;
				end else begin
					tail_d = prv_rd;
				end
				fs_we    = 1'b1;
				fs_wa    = fs_cnt_q[IDX_W-1:0];
				fs_wd    = slot_q;
				fs_cnt_d = fs_cnt_q + CNT_W'(1);
				own_clr  = 1'b1;
				clr_wa   = ent_rd.req[RQ_IDX_W-1:0];
				if (pend_q != '0) pend_d = pend_q - CNT_W'(1);
				tally_re = 1'b1;
				tally_ra = ent_rd.src[SRC_IDX_W-1:0];
				state_d  = ST_U3;
			end
			ST_U3: begin
				tally_wa = ent_rd.src[SRC_IDX_W-1:0];
				tally_wd = (tv_link != '0) ? tv_link - CNT_W'(1) : '0;
				if (cmd_q.op == OP_ENQ) begin
					// older record of this requester is gone, now allocate
					tally_we = 1'b1;
					state_d  = ST_A1;
				end else if (emit_ok) begin
					tally_we = 1'b1;
					emit     = 1'b1;
					e_ent    = ent_rd;
					e_socc   = tally_wd;
					if (cmd_q.op == OP_CANCEL) begin
						e_kind = KIND_CANCELLED;
						e_last = 1'b1;
					end else begin
						e_kind = KIND_DISPATCHED;
						e_last = (k_q + LIM_W'(1) == cmd_q.limit) || head_q == NIL;
					end
					if (e_last) begin
						state_d = ST_IDLE;
					end else begin
						k_d     = k_q + LIM_W'(1);
						slot_d  = head_q[IDX_W-1:0];
						link_re = 1'b1;
						link_ra = head_q[IDX_W-1:0];
						state_d = ST_U2;
					end
				end
			end
			ST_A1: begin
				fs_re    = 1'b1;
				fs_ra    = fs_top[IDX_W-1:0];
				tally_re = cmd_q.src_ok;
				tally_ra = cmd_q.src[SRC_IDX_W-1:0];
				state_d  = ST_A2;
			end
			ST_A2: begin
				if (cmd_q.op == OP_BAD || pend_q == CNT_W'(POOL_DEPTH)) begin
					if (emit_ok) begin
						emit      = 1'b1;
						e_kind    = KIND_REFUSED;
						e_ent.req = cmd_q.req;
						e_ent.src = cmd_q.src;
						e_socc    = tv_cmd;
						state_d   = ST_IDLE;
					end
				end else begin
					if (fr_cnt_q < CNT_W'(POOL_DEPTH)) fr_cnt_d = fr_cnt_q + CNT_W'(1);
					else fs_cnt_d = fs_cnt_q - CNT_W'(1);
					ent_we   = 1'b1;
					ent_wa   = alloc;
					ent_wd   = '{req: cmd_q.req, sel: cmd_q.sel, par: cmd_q.par, src: cmd_q.src};
					nxt_we   = 1'b1;
					nxt_wa   = alloc;
					nxt_wd   = NIL;
					prv_we   = 1'b1;
					prv_wa   = alloc;
					prv_wd   = tail_q;
					own_we   = 1'b1;
					own_wa   = cmd_q.req[RQ_IDX_W-1:0];
					own_wd   = alloc;
					tally_we = 1'b1;
					tally_wa = cmd_q.src[SRC_IDX_W-1:0];
					tally_wd = tv_cmd + CNT_W'(1);
					tnew_d   = tally_wd;
					pend_d   = pend_q + CNT_W'(1);
					if (pend_d > peak_q) peak_d = pend_d;
					tail_d   = PTR_W'(alloc);
					ptr_d    = tail_q;
					slot_d   = alloc;
					state_d  = ST_A3;
				end
			end
			ST_A3: begin
				if (emit_ok) begin
					if (ptr_q != NIL) begin
						nxt_we = 1'b1;
						nxt_wa = ptr_q[IDX_W-1:0];
						nxt_wd = PTR_W'(slot_q);
					end else begin
						head_d = PTR_W'(slot_q);
					end
					emit    = 1'b1;
					e_kind  = KIND_QUEUED;
					e_ent   = '{req: cmd_q.req, sel: cmd_q.sel, par: cmd_q.par, src: cmd_q.src};
					e_socc  = tnew_q;
					state_d = ST_IDLE;
				end
			end
			ST_EMIT3: begin
				if (emit_ok) begin
					emit      = 1'b1;
					e_kind    = KIND_NONE;
					e_ent.req = cmd_q.req;
					state_d   = ST_IDLE;
				end
			end
			ST_EMIT5: begin
				if (emit_ok) begin
					emit    = 1'b1;
					e_kind  = KIND_TICK_IDLE;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= NIL;
			tail_q   <= NIL;
			pend_q   <= '0;
			peak_q   <= '0;
			fs_cnt_q <= '0;
			fr_cnt_q <= '0;
			k_q      <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < NUM_REQUESTERS; i++) own_vld_q[i] <= 1'b0;
			for (int i = 0; i < NUM_SOURCES; i++) tally_vld_q[i] <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			pend_q   <= pend_d;
			peak_q   <= peak_d;
			fs_cnt_q <= fs_cnt_d;
			fr_cnt_q <= fr_cnt_d;
			k_q      <= k_d;
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (own_we) own_vld_q[own_wa] <= 1'b1;
			if (own_clr) own_vld_q[clr_wa] <= 1'b0;
			if (tally_we) tally_vld_q[tally_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		slot_q <= slot_d;
		ptr_q  <= ptr_d;
		tnew_q <= tnew_d;
		if (emit) begin
			result_kind      <= e_kind;
			out_requester    <= e_ent.req;
			out_selection    <= e_ent.sel;
			out_params       <= e_ent.par;
			out_source       <= e_ent.src;
			occupancy        <= 9'(pend_q);
			high_water       <= 9'(peak_q);
			source_occupancy <= 9'(e_socc);
			last_result      <= e_last;
		end
	end

	// memories: one write port, registered read with enable
	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (link_re) begin
			ent_rd <= ent_mem[link_ra];
			nxt_rd <= nxt_mem[link_ra];
			prv_rd <= prv_mem[link_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (fs_we) fs_mem[fs_wa] <= fs_wd;
		if (fs_re) fs_rd <= fs_mem[fs_ra];
	end

	always_ff @(posedge clk) begin
		if (own_we) own_mem[own_wa] <= own_wd;
		if (own_re) own_rd <= own_mem[own_ra[RQ_IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (tally_we) tally_mem[tally_wa] <= tally_wd;
		if (tally_re) tally_rd <= tally_mem[tally_ra];
	end
endmodule

FILE: sv/pending_request_queue_with_cancel_top.sv
// channel   direction  handshake               payload
// in        to block   in_valid / in_ready     action requester selection_index
//                                              move_params source_id
// out       from block out_valid / out_ready   result_kind .. last_result
// cfg       to block   cfg_we                  cfg_wdata (batch_limit)
//
// Items pass a two-entry command queue, then a sequencer that owns the pool memories.
// Cancel looks up the owner record, then unlinks it; enqueue looks up the owner, then allocates
// (an older record of the requester is unlinked first); a tick unlinks each dispatched record,
// and each unlink reads then writes links. Refused enqueue and nothing-to-cancel write no links.
// Reset is asynchronous; no clearing pass, the block takes items right after reset.
// A stalled result holds in the output register while the queue keeps taking items until full.
module pending_request_queue_with_cancel_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  requester,
	input  logic [15:0] selection_index,
	input  logic [31:0] move_params,
	input  logic [5:0]  source_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_kind,
	output logic [7:0]  out_requester,
	output logic [15:0] out_selection,
	output logic [31:0] out_params,
	output logic [5:0]  out_source,
	output logic [8:0]  occupancy,
	output logic [8:0]  high_water,
	output logic [8:0]  source_occupancy,
	output logic        last_result,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);
	import prqc_pkg::*;

	logic [LIM_W-1:0] batch_q;
	logic             q_full, push, cmd_valid, cmd_pop;
	cmd_t             push_cmd, cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) batch_q <= LIM_W'(DEFAULT_BATCH);
		else if (cfg_we) batch_q <= cfg_wdata;
	end

	prqc_front u_front (
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.requester       (requester),
		.selection_index (selection_index),
		.move_params     (move_params),
		.source_id       (source_id),
		.batch_limit     (batch_q),
		.q_full          (q_full),
		.push            (push),
		.cmd             (push_cmd)
	);

	prqc_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (cmd_pop)
	);

	prqc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd              (cmd),
		.cmd_pop          (cmd_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_kind      (result_kind),
		.out_requester    (out_requester),
		.out_selection    (out_selection),
		.out_params       (out_params),
		.out_source       (out_source),
		.occupancy        (occupancy),
		.high_water       (high_water),
		.source_occupancy (source_occupancy),
		.last_result      (last_result)
	);
endmodule

FILE: sv/prqc_checker.sv
`include "pending_request_queue_with_cancel_top_assert.svh"

module prqc_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  result_kind,
	input logic [31:0] out_params,
	input logic [8:0]  occupancy,
	input logic [8:0]  high_water,
	input logic [8:0]  source_occupancy,
	input logic        last_result
);
	import prqc_pkg::*;

	`PRQC_ASSERT_NXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({result_kind, out_params, occupancy}))
	`PRQC_ASSERT_IMP(a_occ_le_peak, clk, arst_n, out_valid, occupancy <= high_water)
	`PRQC_ASSERT_IMP(a_single_last, clk, arst_n, out_valid && result_kind != KIND_DISPATCHED, last_result)
	`PRQC_ASSERT_IMP(a_queued_counts, clk, arst_n, out_valid && result_kind == KIND_QUEUED, occupancy != 9'd0 && source_occupancy != 9'd0)
endmodule

bind pending_request_queue_with_cancel_top prqc_port_checker u_prqc_port_checker (.*);
